// File: rtl/kbtu_pkg.sv
// Shared types and constants for the known-bits transfer unit.
package kbtu_pkg;

	localparam int CNT_BITS = 7;

	typedef enum logic [3:0] {
		MODE_ADD    = 4'd0,
		MODE_SUB    = 4'd1,
		MODE_MUL    = 4'd2,
		MODE_AND    = 4'd3,
		MODE_OR     = 4'd4,
		MODE_XOR    = 4'd5,
		MODE_SHL    = 4'd6,
		MODE_LSHR   = 4'd7,
		MODE_ASHR   = 4'd8,
		MODE_TRUNC  = 4'd9,
		MODE_ZEXT   = 4'd10,
		MODE_SEXT   = 4'd11,
		MODE_SELECT = 4'd12,
		MODE_MEET   = 4'd13,
		MODE_ICMP   = 4'd14
	} kbtu_mode_t;

	typedef enum logic [3:0] {
		PRED_EQ  = 4'd0,
		PRED_NE  = 4'd1,
		PRED_UGT = 4'd2,
		PRED_UGE = 4'd3,
		PRED_ULT = 4'd4,
		PRED_ULE = 4'd5,
		PRED_SGT = 4'd6,
		PRED_SGE = 4'd7,
		PRED_SLT = 4'd8,
		PRED_SLE = 4'd9
	} kbtu_pred_t;

	// Decoded control of one item after width clamping.
	typedef struct packed {
		kbtu_mode_t          mode;
		kbtu_pred_t          pred;
		logic [CNT_BITS-1:0] w;
		logic [CNT_BITS-1:0] rw;
		logic                cz;
		logic                co;
	} kbtu_ctl_t;

	// Control passed from evaluation to the final stage.
	typedef struct packed {
		logic                mul_exact;
		logic [CNT_BITS-1:0] ow;
	} kbtu_res_ctl_t;

endpackage

// File: rtl/kbtu_prep.sv
// Input conditioning: width clamping, operand masking and opcode decode.
module kbtu_prep #(
	parameter int W = 64
) (
	input  logic [3:0]                      mode,
	input  logic [3:0]                      predicate,
	input  logic [kbtu_pkg::CNT_BITS-1:0]   op_width,
	input  logic [kbtu_pkg::CNT_BITS-1:0]   result_width,
	input  logic [W-1:0]                    a_zero,
	input  logic [W-1:0]                    a_one,
	input  logic [W-1:0]                    b_zero,
	input  logic [W-1:0]                    b_one,
	input  logic                            cond_zero,
	input  logic                            cond_one,
	output kbtu_pkg::kbtu_ctl_t             ctl,
	output logic [W-1:0]                    m,
	output logic [W-1:0]                    az,
	output logic [W-1:0]                    ao,
	output logic [W-1:0]                    bz,
	output logic [W-1:0]                    bo
);

	localparam logic [kbtu_pkg::CNT_BITS-1:0] WMAX = kbtu_pkg::CNT_BITS'(W);

	function automatic logic [kbtu_pkg::CNT_BITS-1:0] clamp(
		input logic [kbtu_pkg::CNT_BITS-1:0] n
	);
		logic [kbtu_pkg::CNT_BITS-1:0] r;
		r = n;
		if (n == '0) r = kbtu_pkg::CNT_BITS'(1);
		else if (n > WMAX) r = WMAX;
		return r;
	endfunction

	logic [kbtu_pkg::CNT_BITS-1:0] w_c;

	assign w_c = clamp(op_width);

	always_comb begin
		for (int i = 0; i < W; i++) m[i] = (i < int'(w_c));
	end

	assign az = a_zero & m;
	assign ao = a_one & m;
	assign bz = b_zero & m;
	assign bo = b_one & m;

	assign ctl.mode = kbtu_pkg::kbtu_mode_t'(mode);
	assign ctl.pred = kbtu_pkg::kbtu_pred_t'(predicate);
	assign ctl.w    = w_c;
	assign ctl.rw   = clamp(result_width);
	assign ctl.cz   = cond_zero;
	assign ctl.co   = cond_one;

endmodule

// File: rtl/kbtu_eval.sv
// Per-opcode known-bits evaluation; multiply is split into half-width products.
module kbtu_eval #(
	parameter int W = 64
) (
	input  kbtu_pkg::kbtu_ctl_t         ctl,
	input  logic [W-1:0]                m,
	input  logic [W-1:0]                az,
	input  logic [W-1:0]                ao,
	input  logic [W-1:0]                bz,
	input  logic [W-1:0]                bo,
	output kbtu_pkg::kbtu_res_ctl_t     rctl,
	output logic [W-1:0]                rz,
	output logic [W-1:0]                ro,
	output logic [W-1:0]                om,
	output logic [W-1:0]                pp_ll,
	output logic [W-1:0]                pp_x1,
	output logic [W-1:0]                pp_x2
);

	localparam int LO = (W + 1) / 2;
	localparam int CB = kbtu_pkg::CNT_BITS;

	function automatic logic [W-1:0] wmask(input logic [CB-1:0] n);
		logic [W-1:0] r;
		for (int i = 0; i < W; i++) r[i] = (i < int'(n));
		return r;
	endfunction

	logic          afull, bfull, shift_ok, differs, cmp;
	logic [W-1:0]  sign, sl, sr, v_add, v_sub, high;
	logic [W:0]    ia, ib;
	logic [CB-1:0] ka, kb, kmin, kmul, c, ow;
	logic [CB:0]   ksum;

	assign afull = ((az | ao) & m) == m;
	assign bfull = ((bz | bo) & m) == m;
	assign sign  = W'(1) << (ctl.w - CB'(1));
	assign sl    = ao ^ sign;
	assign sr    = bo ^ sign;
	assign v_add = ao + bo;
	assign v_sub = ao - bo;

	// Lowest clear bit of each known-zero mask marks its run of trailing zeros;
	// the top bit catches a mask that is all ones.
	assign ia = {1'b1, ~az} & ({1'b0, az} + (W + 1)'(1));
	assign ib = {1'b1, ~bz} & ({1'b0, bz} + (W + 1)'(1));

	always_comb begin
		ka = '0;
		kb = '0;
		for (int i = 0; i <= W; i++) begin
			if (ia[i]) ka = ka | CB'(i);
			if (ib[i]) kb = kb | CB'(i);
		end
	end

	assign kmin = (ka < kb) ? ka : kb;
	assign ksum = {1'b0, ka} + {1'b0, kb};
	assign kmul = (ksum > {1'b0, ctl.w}) ? ctl.w : ksum[CB-1:0];

	assign c        = bo[CB-1:0];
	assign shift_ok = bfull && ((bo & sign) == '0) && (bo < W'(ctl.w));
	assign high     = m & ~wmask(ctl.w - c);
	assign differs  = ((ao & bz) | (az & bo)) != '0;

	always_comb begin
		unique case (ctl.pred)
			kbtu_pkg::PRED_EQ:  cmp = (ao == bo);
			kbtu_pkg::PRED_NE:  cmp = (ao != bo);
			kbtu_pkg::PRED_UGT: cmp = (ao > bo);
			kbtu_pkg::PRED_UGE: cmp = (ao >= bo);
			kbtu_pkg::PRED_ULT: cmp = (ao < bo);
			kbtu_pkg::PRED_ULE: cmp = (ao <= bo);
			kbtu_pkg::PRED_SGT: cmp = (sl > sr);
			kbtu_pkg::PRED_SGE: cmp = (sl >= sr);
			kbtu_pkg::PRED_SLT: cmp = (sl < sr);
			kbtu_pkg::PRED_SLE: cmp = (sl <= sr);
			default:            cmp = 1'b0;
		endcase
	end

	always_comb begin
		rz = '0;
		ro = '0;
		ow = ctl.w;
		rctl.mul_exact = 1'b0;
		unique case (ctl.mode)
			kbtu_pkg::MODE_ADD: begin
				if (afull && bfull) begin
					rz = ~v_add;
					ro = v_add;
				end else begin
					rz = wmask(kmin);
				end
			end
			kbtu_pkg::MODE_SUB: begin
				if (afull && bfull) begin
					rz = ~v_sub;
					ro = v_sub;
				end else begin
					rz = wmask(kmin);
				end
			end
			kbtu_pkg::MODE_MUL: begin
				if (afull && bfull) rctl.mul_exact = 1'b1;
				else rz = wmask(kmul);
			end
			kbtu_pkg::MODE_AND: begin
				rz = az | bz;
				ro = ao & bo;
			end
			kbtu_pkg::MODE_OR: begin
				rz = az & bz;
				ro = ao | bo;
			end
			kbtu_pkg::MODE_XOR: begin
				rz = (az & bz) | (ao & bo);
				ro = (az & bo) | (ao & bz);
			end
			kbtu_pkg::MODE_SHL: begin
				if (shift_ok) begin
					rz = (az << c) | wmask(c);
					ro = ao << c;
				end
			end
			kbtu_pkg::MODE_LSHR: begin
				if (shift_ok) begin
					rz = (az >> c) | high;
					ro = ao >> c;
				end
			end
			kbtu_pkg::MODE_ASHR: begin
				if (shift_ok) begin
					rz = az >> c;
					ro = ao >> c;
					if ((az & sign) != '0) rz = rz | high;
					else if ((ao & sign) != '0) ro = ro | high;
				end
			end
			kbtu_pkg::MODE_TRUNC: begin
				ow = ctl.rw;
				rz = az;
				ro = ao;
			end
			kbtu_pkg::MODE_ZEXT: begin
				ow = ctl.rw;
				rz = az | ~m;
				ro = ao;
			end
			kbtu_pkg::MODE_SEXT: begin
				ow = ctl.rw;
				rz = az;
				ro = ao;
				if ((az & sign) != '0) rz = az | ~m;
				else if ((ao & sign) != '0) ro = ao | ~m;
			end
			kbtu_pkg::MODE_SELECT: begin
				if (ctl.co) begin
					rz = az;
					ro = ao;
				end else if (ctl.cz) begin
					rz = bz;
					ro = bo;
				end else begin
					rz = az & bz;
					ro = ao & bo;
				end
			end
			kbtu_pkg::MODE_MEET: begin
				rz = az & bz;
				ro = ao & bo;
			end
			kbtu_pkg::MODE_ICMP: begin
				ow = CB'(1);
				if (afull && bfull) begin
					rz = W'(!cmp);
					ro = W'(cmp);
				end else if (differs) begin
					if (ctl.pred == kbtu_pkg::PRED_EQ) rz = W'(1);
					else if (ctl.pred == kbtu_pkg::PRED_NE) ro = W'(1);
				end
			end
			default: begin
				rz = '0;
				ro = '0;
			end
		endcase
		rctl.ow = ow;
	end

	assign om = wmask(ow);

	// Low W bits of the full product: ll + ((lh + hl) << LO); hh lies above them.
	assign pp_ll = W'(ao[LO-1:0] * bo[LO-1:0]);
	assign pp_x1 = ao[LO-1:0] * bo[W-1:LO];
	assign pp_x2 = ao[W-1:LO] * bo[LO-1:0];

endmodule

// File: rtl/kbtu_fin.sv
// Final stage: product assembly, result masking and constant detection.
module kbtu_fin #(
	parameter int W = 64
) (
	input  kbtu_pkg::kbtu_res_ctl_t         rctl,
	input  logic [W-1:0]                    rz,
	input  logic [W-1:0]                    ro,
	input  logic [W-1:0]                    om,
	input  logic [W-1:0]                    pp_ll,
	input  logic [W-1:0]                    pp_x1,
	input  logic [W-1:0]                    pp_x2,
	output logic [W-1:0]                    res_zero,
	output logic [W-1:0]                    res_one,
	output logic [kbtu_pkg::CNT_BITS-1:0]   res_width,
	output logic                            is_constant
);

	localparam int LO = (W + 1) / 2;

	logic [W-1:0] prod, z, o;

	assign prod = pp_ll + ((pp_x1 + pp_x2) << LO);
	assign z    = (rctl.mul_exact ? ~prod : rz) & om;
	assign o    = (rctl.mul_exact ? prod : ro) & om;

	assign res_zero    = z;
	assign res_one     = o;
	assign res_width   = rctl.ow;
	assign is_constant = ((z | o) == om) && ((z & o) == '0);

endmodule

// File: rtl/known_bits_transfer_unit.sv
// Known-bits transfer unit: top level with the three pipeline registers.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  request | req_valid, req_stall | mode, predicate, op_width, result_width,
//          |                      | a_zero, a_one, b_zero, b_one, cond_zero, cond_one
//  result  | rsp_valid, rsp_stall | res_zero, res_one, res_width, is_constant
//
// After the request transfer an item passes the input register, the evaluation register
// (the multiply is held there as half-width partial products) and the result register.
// One transfer per cycle sustained while rsp_stall is low; a stage loads whenever it
// is empty or its item moves on. Reset clears only the stage valid bits.
// rsp_stall holds the result register; bubbles still fill, so req_stall rises only
// once every stage holds an item.
module known_bits_transfer_unit #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [3:0]                          mode,
	input  logic [3:0]                          predicate,
	input  logic [kbtu_pkg::CNT_BITS-1:0]       op_width,
	input  logic [kbtu_pkg::CNT_BITS-1:0]       result_width,
	input  logic [MAX_WIDTH-1:0]                a_zero,
	input  logic [MAX_WIDTH-1:0]                a_one,
	input  logic [MAX_WIDTH-1:0]                b_zero,
	input  logic [MAX_WIDTH-1:0]                b_one,
	input  logic                                cond_zero,
	input  logic                                cond_one,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [MAX_WIDTH-1:0]                res_zero,
	output logic [MAX_WIDTH-1:0]                res_one,
	output logic [kbtu_pkg::CNT_BITS-1:0]       res_width,
	output logic                                is_constant
);

	localparam int W = MAX_WIDTH;

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	kbtu_pkg::kbtu_ctl_t ctl_d, ctl_s1;
	logic [W-1:0] m_d, az_d, ao_d, bz_d, bo_d;
	logic [W-1:0] m_s1, az_s1, ao_s1, bz_s1, bo_s1;

	kbtu_pkg::kbtu_res_ctl_t rctl_d, rctl_s2;
	logic [W-1:0]  rz_d, ro_d, om_d, px1_d, px2_d;
	logic [W-1:0]  pll_d, pll_s2;
	logic [W-1:0]  rz_s2, ro_s2, om_s2, px1_s2, px2_s2;

	logic [W-1:0]                  zero_d, one_d, zero_s3, one_s3;
	logic [kbtu_pkg::CNT_BITS-1:0] width_d, width_s3;
	logic                          const_d, const_s3;

	assign en3       = !vld_s3 || !rsp_stall;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign req_stall = !en1;

	kbtu_prep #(.W(W)) u_prep (
		.mode         (mode),
		.predicate    (predicate),
		.op_width     (op_width),
		.result_width (result_width),
		.a_zero       (a_zero),
		.a_one        (a_one),
		.b_zero       (b_zero),
		.b_one        (b_one),
		.cond_zero    (cond_zero),
		.cond_one     (cond_one),
		.ctl          (ctl_d),
		.m            (m_d),
		.az           (az_d),
		.ao           (ao_d),
		.bz           (bz_d),
		.bo           (bo_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			ctl_s1 <= ctl_d;
			m_s1   <= m_d;
			az_s1  <= az_d;
			ao_s1  <= ao_d;
			bz_s1  <= bz_d;
			bo_s1  <= bo_d;
		end
	end

	kbtu_eval #(.W(W)) u_eval (
		.ctl   (ctl_s1),
		.m     (m_s1),
		.az    (az_s1),
		.ao    (ao_s1),
		.bz    (bz_s1),
		.bo    (bo_s1),
		.rctl  (rctl_d),
		.rz    (rz_d),
		.ro    (ro_d),
		.om    (om_d),
		.pp_ll (pll_d),
		.pp_x1 (px1_d),
		.pp_x2 (px2_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			rctl_s2 <= rctl_d;
			rz_s2   <= rz_d;
			ro_s2   <= ro_d;
			om_s2   <= om_d;
			pll_s2  <= pll_d;
			px1_s2  <= px1_d;
			px2_s2  <= px2_d;
		end
	end

	kbtu_fin #(.W(W)) u_fin (
		.rctl        (rctl_s2),
		.rz          (rz_s2),
		.ro          (ro_s2),
		.om          (om_s2),
		.pp_ll       (pll_s2),
		.pp_x1       (px1_s2),
		.pp_x2       (px2_s2),
		.res_zero    (zero_d),
		.res_one     (one_d),
		.res_width   (width_d),
		.is_constant (const_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			zero_s3  <= zero_d;
			one_s3   <= one_d;
			width_s3 <= width_d;
			const_s3 <= const_d;
		end
	end

	assign rsp_valid   = vld_s3;
	assign res_zero    = zero_s3;
	assign res_one     = one_s3;
	assign res_width   = width_s3;
	assign is_constant = const_s3;

endmodule
